// ===== rtl/krrt_pkg.sv =====
// Shared types and constants for the keyboard rollover report tracker.
package krrt_pkg;

   localparam int unsigned SLOT_STORE = 6;
   localparam logic [7:0] KEYBOARD_ID = 8'd1;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef enum logic [2:0] {
      ACT_PRESS       = 3'd0,
      ACT_RELEASE     = 3'd1,
      ACT_RELEASE_ALL = 3'd2,
      ACT_ATTACH      = 3'd3,
      ACT_DETACH      = 3'd4,
      ACT_HOST_REPORT = 3'd5
   } krrt_action_type;

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_PRESS,
      TBL_RELEASE,
      TBL_CLEAR
   } krrt_tbl_op_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_SCAN,
      TS_WRITE,
      TS_DONE
   } krrt_tbl_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_RESP
   } krrt_state_type;

   typedef struct packed {
      logic            start;
      krrt_tbl_op_type op;
      logic [7:0]      code;
   } krrt_tbl_cmd_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] button_code;
      logic        endpoint_ready;
      logic [7:0]  report_ident;
      logic        report_is_output;
      logic [6:0]  report_length;
      logic [7:0]  led_bits;
   } krrt_req_type;

   typedef struct packed {
      logic       report_sent;
      logic [7:0] modifier_byte;
      logic [7:0] slot_zero;
      logic [7:0] slot_one;
      logic [7:0] slot_two;
      logic [7:0] slot_three;
      logic [7:0] slot_four;
      logic [7:0] slot_five;
      logic       attached;
      logic [7:0] host_leds;
   } krrt_rsp_type;

endpackage

// ===== rtl/krrt_channels.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface krrt_req_if;
   logic                  valid;
   logic                  ready;
   krrt_pkg::krrt_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface krrt_rsp_if;
   logic                  valid;
   logic                  ready;
   krrt_pkg::krrt_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/krrt_key_table.sv =====
// Held-key table with one shared slot comparator stepped by a small sequencer.
module krrt_key_table #(
   parameter int unsigned KEY_SLOTS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  krrt_pkg::krrt_tbl_cmd_type   cmd,
   output logic                         done,
   output logic [KEY_SLOTS-1:0][7:0]    slots
);

   localparam int unsigned CntW = $clog2(KEY_SLOTS + 1);
   localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [CntW-1:0] LastIdx = CntW'(KEY_SLOTS - 1);

   krrt_pkg::krrt_tbl_state_type state_ff, state_in;
   krrt_pkg::krrt_tbl_op_type    op_ff, op_in;
   logic [7:0]                   code_ff, code_in;
   logic [CntW-1:0]              idx_ff, idx_in;
   logic [CntW-1:0]              wr_ff, wr_in;
   logic                         found_ff, found_in;
   logic                         has_empty_ff, has_empty_in;
   logic [IdxW-1:0]              empty_idx_ff, empty_idx_in;
   logic [KEY_SLOTS-1:0][7:0]    slots_ff, slots_in;

   logic [7:0] cur;
   logic       hit;
   logic       empty;
   logic       last;

   // shared compare unit on the slot under the scan pointer
   assign cur   = slots_ff[idx_ff[IdxW-1:0]];
   assign hit   = (cur == code_ff);
   assign empty = (cur == krrt_pkg::BYTE_ZERO);
   assign last  = (idx_ff == LastIdx);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         krrt_pkg::TS_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == krrt_pkg::TBL_PRESS || cmd.op == krrt_pkg::TBL_RELEASE) begin
                  state_in = krrt_pkg::TS_SCAN;
               end else begin
                  state_in = krrt_pkg::TS_DONE;
               end
            end
         end
         krrt_pkg::TS_SCAN: begin
            if (last) begin
               state_in = (op_ff == krrt_pkg::TBL_PRESS) ? krrt_pkg::TS_WRITE
                                                          : krrt_pkg::TS_DONE;
            end
         end
         krrt_pkg::TS_WRITE: state_in = krrt_pkg::TS_DONE;
         krrt_pkg::TS_DONE:  state_in = krrt_pkg::TS_IDLE;
         default:            state_in = krrt_pkg::TS_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == krrt_pkg::TS_DONE);
   end

   always_comb begin
      op_in        = op_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      found_in     = found_ff;
      has_empty_in = has_empty_ff;
      empty_idx_in = empty_idx_ff;
      slots_in     = slots_ff;
      case (state_ff)
         krrt_pkg::TS_IDLE: begin
            if (cmd.start) begin
               op_in        = cmd.op;
               code_in      = cmd.code;
               idx_in       = '0;
               wr_in        = '0;
               found_in     = 1'b0;
               has_empty_in = 1'b0;
               if (cmd.op == krrt_pkg::TBL_CLEAR) begin
                  slots_in = '0;
               end
            end
         end
         krrt_pkg::TS_SCAN: begin
            idx_in = idx_ff + CntW'(1);
            if (op_ff == krrt_pkg::TBL_PRESS) begin
               if (hit) begin
                  found_in = 1'b1;
               end
               if (empty && !has_empty_ff) begin
                  has_empty_in = 1'b1;
                  empty_idx_in = idx_ff[IdxW-1:0];
               end
            end else begin
               // pack survivors down to the write pointer, vacate the rest
               if (!empty && !hit) begin
                  slots_in[wr_ff[IdxW-1:0]] = cur;
                  if (wr_ff != idx_ff) begin
                     slots_in[idx_ff[IdxW-1:0]] = krrt_pkg::BYTE_ZERO;
                  end
                  wr_in = wr_ff + CntW'(1);
               end else begin
                  slots_in[idx_ff[IdxW-1:0]] = krrt_pkg::BYTE_ZERO;
               end
            end
         end
         krrt_pkg::TS_WRITE: begin
            if (!found_ff && has_empty_ff) begin
               slots_in[empty_idx_ff] = code_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krrt_pkg::TS_IDLE;
         slots_ff <= '0;
      end else begin
         state_ff <= state_in;
         slots_ff <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      code_ff      <= code_in;
      idx_ff       <= idx_in;
      wr_ff        <= wr_in;
      found_ff     <= found_in;
      has_empty_ff <= has_empty_in;
      empty_idx_ff <= empty_idx_in;
   end

   assign slots = slots_ff;

endmodule

// ===== rtl/keyboard_rollover_report_tracker.sv =====
// Top level of the keyboard rollover report tracker.
//
// Keeps the state behind a boot keyboard report (modifier byte, up to
// KEY_SLOTS held keycodes, attach flag and host LED byte) and returns one
// response beat for every request beat. One request is in flight at a time:
// req_ch.ready is high only while the block is idle and drops until the
// response beat has been taken. Attach, host report, release all, detach,
// unused codes and keycode-zero key actions skip the slot walk; a release
// walks the slots once and a press walks them and then writes. Ready
// returns the cycle after the response beat, and the next request beat can
// be taken then; a stall on the response side holds the block until the
// response beat is taken. The key table walks the slots one per cycle
// through a single shared comparator: a press looks for a duplicate and the
// first empty slot, then writes; a release removes the code and packs the
// survivors toward slot zero during the same walk. Slots at or beyond
// KEY_SLOTS read back as zero.
module keyboard_rollover_report_tracker #(
   parameter int unsigned KEY_SLOTS = 6
) (
   input  logic           clock,
   input  logic           reset,
   krrt_req_if.sink       req_ch,
   krrt_rsp_if.source     rsp_ch
);

   krrt_pkg::krrt_state_type   state_ff, state_in;
   logic [7:0]                 mod_ff, mod_in;
   logic                       attached_ff, attached_in;
   logic [7:0]                 leds_ff, leds_in;
   logic                       sent_ff, sent_in;
   krrt_pkg::krrt_tbl_cmd_type cmd_ff, cmd_in;
   krrt_pkg::krrt_rsp_type     rsp_ff, rsp_in;

   logic                       req_accept;
   logic                       tbl_done;
   logic [KEY_SLOTS-1:0][7:0]  tbl_slots;
   logic [krrt_pkg::SLOT_STORE-1:0][7:0] slot_view;
   logic [7:0]                 key_code;
   logic [7:0]                 key_mods;
   logic                       key_action;
   krrt_pkg::krrt_tbl_op_type  tbl_op;

   krrt_key_table #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_key_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .done  (tbl_done),
      .slots (tbl_slots)
   );

   // Unused report slots read as zero.
   for (genvar j = 0; j < krrt_pkg::SLOT_STORE; j++) begin : g_view
      if (j < KEY_SLOTS) begin : g_used
         assign slot_view[j] = tbl_slots[j];
      end else begin : g_unused
         assign slot_view[j] = krrt_pkg::BYTE_ZERO;
      end
   end

   assign req_accept = req_ch.valid && req_ch.ready;
   assign key_code   = req_ch.payload.button_code[7:0];
   assign key_mods   = req_ch.payload.button_code[15:8];

   // Next state of the request/response sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         krrt_pkg::ST_IDLE: if (req_accept)      state_in = krrt_pkg::ST_WAIT;
         krrt_pkg::ST_WAIT: if (tbl_done)        state_in = krrt_pkg::ST_RESP;
         krrt_pkg::ST_RESP: if (rsp_ch.ready)    state_in = krrt_pkg::ST_IDLE;
         default:                                state_in = krrt_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs follow the sequencer state.
   always_comb begin
      req_ch.ready = (state_ff == krrt_pkg::ST_IDLE);
      rsp_ch.valid = (state_ff == krrt_pkg::ST_RESP);
   end

   // Decode the request beat: update the scalar state right away and hand
   // any slot work to the key table.
   always_comb begin
      mod_in      = mod_ff;
      attached_in = attached_ff;
      leds_in     = leds_ff;
      sent_in     = sent_ff;
      cmd_in      = cmd_ff;
      key_action  = 1'b0;
      tbl_op      = krrt_pkg::TBL_NONE;
      cmd_in.start = 1'b0;
      if (req_accept) begin
         case (req_ch.payload.action)
            krrt_pkg::ACT_PRESS: begin
               mod_in     = mod_ff | key_mods;
               key_action = 1'b1;
               if (key_code != krrt_pkg::BYTE_ZERO) tbl_op = krrt_pkg::TBL_PRESS;
            end
            krrt_pkg::ACT_RELEASE: begin
               mod_in     = mod_ff & ~key_mods;
               key_action = 1'b1;
               if (key_code != krrt_pkg::BYTE_ZERO) tbl_op = krrt_pkg::TBL_RELEASE;
            end
            krrt_pkg::ACT_RELEASE_ALL: begin
               mod_in     = krrt_pkg::BYTE_ZERO;
               key_action = 1'b1;
               tbl_op     = krrt_pkg::TBL_CLEAR;
            end
            krrt_pkg::ACT_ATTACH: begin
               attached_in = 1'b1;
            end
            krrt_pkg::ACT_DETACH: begin
               attached_in = 1'b0;
               mod_in      = krrt_pkg::BYTE_ZERO;
               leds_in     = krrt_pkg::BYTE_ZERO;
               tbl_op      = krrt_pkg::TBL_CLEAR;
            end
            krrt_pkg::ACT_HOST_REPORT: begin
               // take the LED byte only from a keyboard output report with payload
               if (req_ch.payload.report_is_output
                   && req_ch.payload.report_ident == krrt_pkg::KEYBOARD_ID
                   && req_ch.payload.report_length != '0) begin
                  leds_in = req_ch.payload.led_bits;
               end
            end
            default: begin
            end
         endcase
         // attach state is untouched by key actions, so the old flag decides
         sent_in      = key_action && attached_ff && req_ch.payload.endpoint_ready;
         cmd_in.start = 1'b1;
         cmd_in.op    = tbl_op;
         cmd_in.code  = key_code;
      end
   end

   // Capture the response beat once the table has settled.
   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == krrt_pkg::ST_WAIT && tbl_done) begin
         rsp_in.report_sent   = sent_ff;
         rsp_in.modifier_byte = mod_ff;
         rsp_in.slot_zero     = slot_view[0];
         rsp_in.slot_one      = slot_view[1];
         rsp_in.slot_two      = slot_view[2];
         rsp_in.slot_three    = slot_view[3];
         rsp_in.slot_four     = slot_view[4];
         rsp_in.slot_five     = slot_view[5];
         rsp_in.attached      = attached_ff;
         rsp_in.host_leds     = leds_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= krrt_pkg::ST_IDLE;
         mod_ff      <= krrt_pkg::BYTE_ZERO;
         attached_ff <= 1'b0;
         leds_ff     <= krrt_pkg::BYTE_ZERO;
         cmd_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         mod_ff      <= mod_in;
         attached_ff <= attached_in;
         leds_ff     <= leds_in;
         cmd_ff      <= cmd_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      sent_ff <= sent_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.payload = rsp_ff;

endmodule

// ===== rtl/krrt_checker.sv =====
// Port-level checks for the keyboard rollover report tracker, bound to the top level.
module krrt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input krrt_pkg::krrt_rsp_type rsp_payload
);

   // one beat in flight: never ready for a request while a response waits
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // a response never shows up in the cycle right after a request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("response or ready right after request accept");

   // after a response beat the block is ready for the next request
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("block not idle after response accept");

   // a report is only sent while attached
   a_sent_attached: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.report_sent) |-> rsp_payload.attached)
      else $error("report sent while detached");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind keyboard_rollover_report_tracker krrt_checker u_krrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// ===== verif/krrt_report_check.sv =====
// Report predictor and response comparison for the keyboard rollover report tracker.
`timescale 1ns / 100ps
module krrt_report_check #(
   parameter int unsigned KEY_SLOTS = 6
) (
   input  logic        clock,
   input  logic        reset,
   krrt_req_if         req_ch,
   krrt_rsp_if         rsp_ch,
   output int unsigned fail_count,
   output int unsigned pending_reports,
   output int unsigned reports_checked,
   output int unsigned full_drops
);

   localparam int unsigned LIVE_SLOTS =
      (KEY_SLOTS > krrt_pkg::SLOT_STORE) ? krrt_pkg::SLOT_STORE
                                         : ((KEY_SLOTS < 1) ? 1 : KEY_SLOTS);

   logic [7:0]             held[krrt_pkg::SLOT_STORE];
   logic [7:0]             modifiers;
   logic                   host_attached;
   logic [7:0]             leds;
   krrt_pkg::krrt_rsp_type expected_reports[$];
   int unsigned            errors;
   int unsigned            checked;
   int unsigned            drops;

   function automatic logic [7:0] slot_value(int unsigned idx);
      return (idx < LIVE_SLOTS) ? held[idx] : krrt_pkg::BYTE_ZERO;
   endfunction

   // Apply one request to the tracked state and build the report it yields.
   function automatic krrt_pkg::krrt_rsp_type advance_tracker(krrt_pkg::krrt_req_type beat);
      krrt_pkg::krrt_rsp_type report;
      logic [7:0]   code;
      logic [7:0]   mods;
      logic [7:0]   kept[krrt_pkg::SLOT_STORE];
      int unsigned  fill;
      logic         key_action;
      logic         found;
      code = beat.button_code[7:0];
      mods = beat.button_code[15:8];
      key_action = 1'b0;
      case (beat.action)
         krrt_pkg::ACT_PRESS: begin
            key_action = 1'b1;
            modifiers = modifiers | mods;
            if (code != krrt_pkg::BYTE_ZERO) begin
               found = 1'b0;
               for (int i = 0; i < LIVE_SLOTS; i++)
                  if (held[i] == code) found = 1'b1;
               if (!found) begin
                  for (int i = 0; i < LIVE_SLOTS && !found; i++)
                     if (held[i] == krrt_pkg::BYTE_ZERO) begin
                        held[i] = code;
                        found = 1'b1;
                     end
                  // no free slot: drop the code, the modifiers still stick
                  if (!found) drops++;
               end
            end
         end
         krrt_pkg::ACT_RELEASE: begin
            key_action = 1'b1;
            modifiers = modifiers & ~mods;
            if (code != krrt_pkg::BYTE_ZERO) begin
               fill = 0;
               kept = '{default: krrt_pkg::BYTE_ZERO};
               for (int i = 0; i < LIVE_SLOTS; i++)
                  if (held[i] != krrt_pkg::BYTE_ZERO && held[i] != code) begin
                     kept[fill] = held[i];
                     fill++;
                  end
               held = kept;
            end
         end
         krrt_pkg::ACT_RELEASE_ALL: begin
            key_action = 1'b1;
            modifiers = krrt_pkg::BYTE_ZERO;
            held = '{default: krrt_pkg::BYTE_ZERO};
         end
         krrt_pkg::ACT_ATTACH: host_attached = 1'b1;
         krrt_pkg::ACT_DETACH: begin
            host_attached = 1'b0;
            held = '{default: krrt_pkg::BYTE_ZERO};
            modifiers = krrt_pkg::BYTE_ZERO;
            leds = krrt_pkg::BYTE_ZERO;
         end
         krrt_pkg::ACT_HOST_REPORT: begin
            if (beat.report_is_output && beat.report_ident == krrt_pkg::KEYBOARD_ID &&
                beat.report_length != 7'd0)
               leds = beat.led_bits;
         end
         default: ;
      endcase
      report.report_sent = key_action && host_attached && beat.endpoint_ready;
      report.modifier_byte = modifiers;
      report.slot_zero = slot_value(0);
      report.slot_one = slot_value(1);
      report.slot_two = slot_value(2);
      report.slot_three = slot_value(3);
      report.slot_four = slot_value(4);
      report.slot_five = slot_value(5);
      report.attached = host_attached;
      report.host_leds = leds;
      return report;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_beats
      krrt_pkg::krrt_rsp_type want;
      if (reset) begin
         held = '{default: krrt_pkg::BYTE_ZERO};
         modifiers = krrt_pkg::BYTE_ZERO;
         host_attached = 1'b0;
         leds = krrt_pkg::BYTE_ZERO;
         expected_reports.delete();
         errors = 0;
         checked = 0;
         drops = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: response beat expected none, got %h",
                        $time, rsp_ch.payload);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("report_sent", 8'(want.report_sent),
                           8'(rsp_ch.payload.report_sent));
               check_field("modifier_byte", want.modifier_byte,
                           rsp_ch.payload.modifier_byte);
               check_field("slot_zero", want.slot_zero, rsp_ch.payload.slot_zero);
               check_field("slot_one", want.slot_one, rsp_ch.payload.slot_one);
               check_field("slot_two", want.slot_two, rsp_ch.payload.slot_two);
               check_field("slot_three", want.slot_three, rsp_ch.payload.slot_three);
               check_field("slot_four", want.slot_four, rsp_ch.payload.slot_four);
               check_field("slot_five", want.slot_five, rsp_ch.payload.slot_five);
               check_field("attached", 8'(want.attached), 8'(rsp_ch.payload.attached));
               check_field("host_leds", want.host_leds, rsp_ch.payload.host_leds);
               checked++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_reports.push_back(advance_tracker(req_ch.payload));
      end
      fail_count <= errors;
      pending_reports <= expected_reports.size();
      reports_checked <= checked;
      full_drops <= drops;
   end

endmodule

// ===== verif/keyboard_rollover_report_tracker_test.sv =====
// Testbench top for the keyboard rollover report tracker: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module keyboard_rollover_report_tracker_test;

   localparam int unsigned KEY_SLOTS = 6;
   localparam int unsigned RANDOM_BEATS = 1680;
   localparam int unsigned IDLE_LIMIT = 2000;
   // Slowest request is a press, which walks the slots and then writes; leave margin after it.
   localparam int unsigned DRAIN_CYCLES = 3 * (KEY_SLOTS + 4);

   // Action codes outside the defined set; the block must ignore them.
   localparam logic [2:0] ACT_UNUSED_SIX = 3'd6;
   localparam logic [2:0] ACT_UNUSED_SEVEN = 3'd7;

   logic clock;
   logic reset;

   krrt_req_if req_ch ();
   krrt_rsp_if rsp_ch ();

   int unsigned mismatches;
   int unsigned pending_reports;
   int unsigned reports_checked;
   int unsigned full_drops;
   int unsigned idle_cycles = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned beats_sent = 0;
   int unsigned press_beats = 0;
   int unsigned release_beats = 0;
   int unsigned host_beats = 0;
   // While set, neither side starts a new idle gap.
   bit calm = 1'b0;

   keyboard_rollover_report_tracker #(.KEY_SLOTS(KEY_SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   krrt_report_check #(.KEY_SLOTS(KEY_SLOTS)) report_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .fail_count      (mismatches),
      .pending_reports (pending_reports),
      .reports_checked (reports_checked),
      .full_drops      (full_drops)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic krrt_pkg::krrt_req_type make_request(logic [2:0] action,
                                                           logic [15:0] button,
                                                           logic ready, logic [7:0] rid,
                                                           logic is_out, logic [6:0] len,
                                                           logic [7:0] led_byte);
      krrt_pkg::krrt_req_type beat;
      beat.action = action;
      beat.button_code = button;
      beat.endpoint_ready = ready;
      beat.report_ident = rid;
      beat.report_is_output = is_out;
      beat.report_length = len;
      beat.led_bits = led_byte;
      return beat;
   endfunction

   // Keycodes come mostly from a small pool so that duplicates, full tables
   // and releases of held keys happen often.
   function automatic krrt_pkg::krrt_req_type random_request();
      krrt_pkg::krrt_req_type beat;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         beat.button_code[7:0] = 8'h00;
      else if (roll < 80)
         beat.button_code[7:0] = 8'($urandom_range(1, 10));
      else
         beat.button_code[7:0] = 8'($urandom_range(0, 255));
      beat.button_code[15:8] = ($urandom_range(0, 99) < 40) ? 8'h00 : 8'($urandom_range(0, 255));
      beat.endpoint_ready = $urandom_range(0, 99) < 80;
      beat.report_ident = $urandom_range(0, 1) ? krrt_pkg::KEYBOARD_ID
                                               : 8'($urandom_range(0, 255));
      beat.report_is_output = 1'($urandom_range(0, 1));
      beat.report_length = 7'($urandom_range(0, 64));
      beat.led_bits = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 44)
         beat.action = krrt_pkg::ACT_PRESS;
      else if (roll < 69)
         beat.action = krrt_pkg::ACT_RELEASE;
      else if (roll < 73)
         beat.action = krrt_pkg::ACT_RELEASE_ALL;
      else if (roll < 81)
         beat.action = krrt_pkg::ACT_ATTACH;
      else if (roll < 84)
         beat.action = krrt_pkg::ACT_DETACH;
      else if (roll < 98) begin
         beat.action = krrt_pkg::ACT_HOST_REPORT;
         // most host reports pass the filter, the rest are random noise
         if ($urandom_range(0, 99) < 70) begin
            beat.report_ident = krrt_pkg::KEYBOARD_ID;
            beat.report_is_output = 1'b1;
            beat.report_length = 7'($urandom_range(1, 64));
         end
      end else
         beat.action = roll[0] ? ACT_UNUSED_SIX : ACT_UNUSED_SEVEN;
      return beat;
   endfunction

   // Hold valid until the beat is taken; keep it high across back-to-back beats.
   task automatic send_beat(krrt_pkg::krrt_req_type beat);
      int unsigned gap;
      gap = calm ? 0 : idle_length();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= beat;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
      case (beat.action)
         krrt_pkg::ACT_PRESS: press_beats++;
         krrt_pkg::ACT_RELEASE: release_beats++;
         krrt_pkg::ACT_HOST_REPORT: host_beats++;
         default: ;
      endcase
   endtask

   task automatic run_directed();
      // key action while detached: state moves, nothing sent
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h0204, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_HOST_REPORT, 16'h0000, 1'b0,
                             krrt_pkg::KEYBOARD_ID, 1'b1, 7'd1, 8'hFF));
      // attach twice: the second one changes nothing
      send_beat(make_request(krrt_pkg::ACT_ATTACH, 16'h0000, 1'b0, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_ATTACH, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 7'd64,
                             8'hFF));
      // largest code and all modifiers, then the same code again
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'hFFFF, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h00FF, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      // fill the table, then press one more code into a full table
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h0005, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h0006, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h0007, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h0001, 1'b0, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h4009, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      // release from the middle, then keycode zero on both key actions
      send_beat(make_request(krrt_pkg::ACT_RELEASE, 16'h0106, 1'b1, 8'h00, 1'b0, 7'd0,
                             8'h00));
      send_beat(make_request(krrt_pkg::ACT_RELEASE, 16'h8000, 1'b0, 8'h00, 1'b0, 7'd0,
                             8'h00));
      send_beat(make_request(krrt_pkg::ACT_PRESS, 16'h1000, 1'b0, 8'h00, 1'b0, 7'd0, 8'h00));
      // release slot zero, a code not held, and the largest code with all modifiers
      send_beat(make_request(krrt_pkg::ACT_RELEASE, 16'h0004, 1'b1, 8'h00, 1'b0, 7'd0,
                             8'h00));
      send_beat(make_request(krrt_pkg::ACT_RELEASE, 16'h0033, 1'b1, 8'h00, 1'b0, 7'd0,
                             8'h00));
      send_beat(make_request(krrt_pkg::ACT_RELEASE, 16'hFFFF, 1'b1, 8'h00, 1'b0, 7'd0,
                             8'h00));
      // host reports that miss the filter on each term, then one that passes
      send_beat(make_request(krrt_pkg::ACT_HOST_REPORT, 16'h0000, 1'b1, 8'h02, 1'b1, 7'd1,
                             8'h3C));
      send_beat(make_request(krrt_pkg::ACT_HOST_REPORT, 16'h0000, 1'b1,
                             krrt_pkg::KEYBOARD_ID, 1'b0, 7'd8, 8'h3C));
      send_beat(make_request(krrt_pkg::ACT_HOST_REPORT, 16'h0000, 1'b1,
                             krrt_pkg::KEYBOARD_ID, 1'b1, 7'd0, 8'h3C));
      send_beat(make_request(krrt_pkg::ACT_HOST_REPORT, 16'h0000, 1'b1,
                             krrt_pkg::KEYBOARD_ID, 1'b1, 7'd64, 8'hA5));
      send_beat(make_request(ACT_UNUSED_SIX, 16'h0A0B, 1'b1, krrt_pkg::KEYBOARD_ID, 1'b1,
                             7'd1, 8'h11));
      send_beat(make_request(ACT_UNUSED_SEVEN, 16'h0A0B, 1'b1, krrt_pkg::KEYBOARD_ID, 1'b1,
                             7'd1, 8'h11));
      send_beat(make_request(krrt_pkg::ACT_RELEASE_ALL, 16'h0000, 1'b1, 8'h00, 1'b0, 7'd0,
                             8'h00));
      // detach while attached and again while detached, then attach for the random part
      send_beat(make_request(krrt_pkg::ACT_DETACH, 16'h0000, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_DETACH, 16'h0000, 1'b1, 8'h00, 1'b0, 7'd0, 8'h00));
      send_beat(make_request(krrt_pkg::ACT_ATTACH, 16'h0000, 1'b0, 8'h00, 1'b0, 7'd0, 8'h00));
   endtask

   // Response side: stall at random, with calm stretches of steady ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall_left <= 0;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_stall_left <= idle_length();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // every fourth stretch of 160 beats runs without idle cycles
         calm = ((n / 160) % 4) == 2;
         // halfway through, drop valid and let every report drain first
         if (n == RANDOM_BEATS / 2) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending_reports != 0);
         end
         send_beat(random_request());
      end
      calm = 1'b0;

      // drop valid, drain the outstanding reports, then watch for strays
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_reports != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d press, %0d release, %0d host report, gaps on both sides.",
               beats_sent, press_beats, release_beats, host_beats);
      $display("Compared %0d reports; %0d presses hit a full key table.",
               reports_checked, full_drops);
      if (mismatches == 0 && pending_reports == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/krrt_pkg.sv
rtl/krrt_channels.sv
rtl/krrt_key_table.sv
rtl/keyboard_rollover_report_tracker.sv
rtl/krrt_checker.sv
verif/krrt_report_check.sv
verif/keyboard_rollover_report_tracker_test.sv
